>>> rtl/char_range_expander_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the range expander
// Shared property forms; they compile away when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef CHAR_RANGE_EXPANDER_CORE_MACROS_SVH
`define CHAR_RANGE_EXPANDER_CORE_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every clock edge outside reset.
`define CRE_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define CRE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CRE_ASSERT_IMPL(lbl, ante, cons, msg)
`define CRE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/cre_pkg.sv
// ---------------------------------------------------------------------------
// Range expander package
// Item types, microcode word layout, step numbers and character classes.
// ---------------------------------------------------------------------------
package cre_pkg;

	localparam logic [7:0] DASH_BYTE = 8'h2D;
	localparam logic [7:0] TERM_BYTE = 8'h00;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_end;
	} out_item_t;

	typedef logic [3:0] step_t;

	// Program step numbers.
	localparam step_t STEP_WAIT  = 4'd0;
	localparam step_t STEP_DISP  = 4'd1;
	localparam step_t STEP_CLASS = 4'd2;
	localparam step_t STEP_RANGE = 4'd3;
	localparam step_t STEP_DASH  = 4'd4;
	localparam step_t STEP_BODY  = 4'd5;
	localparam step_t STEP_PASS  = 4'd6;
	localparam step_t STEP_SEEN  = 4'd7;
	localparam step_t STEP_FLUSH = 4'd8;
	localparam step_t STEP_TERM  = 4'd9;

	typedef enum logic [2:0] {
		EMIT_NONE,
		EMIT_CNT,
		EMIT_DASH,
		EMIT_BYTE,
		EMIT_TERM
	} emit_sel_t;

	typedef enum logic [1:0] {
		PREV_KEEP,
		PREV_BYTE,
		PREV_DASH,
		PREV_ZERO
	} prev_op_t;

	typedef enum logic [1:0] {
		CNT_KEEP,
		CNT_LOAD,
		CNT_INC
	} cnt_op_t;

	typedef enum logic [1:0] {
		FLAG_KEEP,
		FLAG_SET,
		FLAG_CLR
	} flag_op_t;

	typedef enum logic [1:0] {
		ACT_ALWAYS,
		ACT_ON_TRUE,
		ACT_ON_FALSE
	} act_when_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_ACCEPT,
		COND_DASH,
		COND_SAME,
		COND_DONE,
		COND_HOLD,
		COND_LAST
	} cond_t;

	typedef struct packed {
		logic      in_ready;
		emit_sel_t emit;
		prev_op_t  prev_op;
		cnt_op_t   cnt_op;
		flag_op_t  dash_op;
		flag_op_t  seen_op;
		act_when_t act;
		cond_t     cond;
		step_t     jt;
		step_t     jf;
	} uword_t;

	localparam uword_t UW_NOP = '{
		in_ready: 1'b0,
		emit:     EMIT_NONE,
		prev_op:  PREV_KEEP,
		cnt_op:   CNT_KEEP,
		dash_op:  FLAG_KEEP,
		seen_op:  FLAG_KEEP,
		act:      ACT_ALWAYS,
		cond:     COND_ALWAYS,
		jt:       STEP_WAIT,
		jf:       STEP_WAIT
	};

	// Datapath flags seen by the sequencer.
	typedef struct packed {
		logic accept;
		logic dash_held;
		logic same_class;
		logic range_done;
		logic hold_dash;
		logic last;
		logic out_blocked;
	} dp_status_t;

	// Sequencer commands to the datapath.
	typedef struct packed {
		uword_t uw;
		logic   fire;
	} dp_ctrl_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] b);
		return ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
	endfunction

endpackage

>>> rtl/cre_urom.sv
// ---------------------------------------------------------------------------
// Range expander microcode ROM
// One control word per program step.
// ---------------------------------------------------------------------------
module cre_urom import cre_pkg::*; (
	input  step_t  upc,
	output uword_t uw
);

	always_comb begin
		uw = UW_NOP;
		case (upc)
			STEP_WAIT: begin
				uw.in_ready = 1'b1;
				uw.cond     = COND_ACCEPT;
				uw.jt       = STEP_DISP;
				uw.jf       = STEP_WAIT;
			end
			STEP_DISP: begin
				uw.cond = COND_DASH;
				uw.jt   = STEP_CLASS;
				uw.jf   = STEP_BODY;
			end
			STEP_CLASS: begin
				// The range start is taken from the old previous byte.
				uw.dash_op = FLAG_CLR;
				uw.cnt_op  = CNT_LOAD;
				uw.prev_op = PREV_BYTE;
				uw.cond    = COND_SAME;
				uw.jt      = STEP_RANGE;
				uw.jf      = STEP_DASH;
			end
			STEP_RANGE: begin
				uw.emit   = EMIT_CNT;
				uw.cnt_op = CNT_INC;
				uw.act    = ACT_ON_FALSE;
				uw.cond   = COND_DONE;
				uw.jt     = STEP_SEEN;
				uw.jf     = STEP_RANGE;
			end
			STEP_DASH: begin
				uw.emit    = EMIT_DASH;
				uw.prev_op = PREV_DASH;
				uw.jt      = STEP_BODY;
				uw.jf      = STEP_BODY;
			end
			STEP_BODY: begin
				uw.dash_op = FLAG_SET;
				uw.act     = ACT_ON_TRUE;
				uw.cond    = COND_HOLD;
				uw.jt      = STEP_SEEN;
				uw.jf      = STEP_PASS;
			end
			STEP_PASS: begin
				uw.emit    = EMIT_BYTE;
				uw.prev_op = PREV_BYTE;
				uw.jt      = STEP_SEEN;
				uw.jf      = STEP_SEEN;
			end
			STEP_SEEN: begin
				uw.seen_op = FLAG_SET;
				uw.cond    = COND_LAST;
				uw.jt      = STEP_FLUSH;
				uw.jf      = STEP_WAIT;
			end
			STEP_FLUSH: begin
				uw.emit = EMIT_DASH;
				uw.act  = ACT_ON_TRUE;
				uw.cond = COND_DASH;
				uw.jt   = STEP_TERM;
				uw.jf   = STEP_TERM;
			end
			STEP_TERM: begin
				uw.emit    = EMIT_TERM;
				uw.prev_op = PREV_ZERO;
				uw.dash_op = FLAG_CLR;
				uw.seen_op = FLAG_CLR;
				uw.jt      = STEP_WAIT;
				uw.jf      = STEP_WAIT;
			end
			default: begin
				uw = UW_NOP;
			end
		endcase
	end

endmodule

>>> rtl/cre_seq.sv
// ---------------------------------------------------------------------------
// Range expander sequencer
// Step counter, condition select and two-way jump.
// ---------------------------------------------------------------------------
module cre_seq import cre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_status_t status,
	output step_t      upc,
	output dp_ctrl_t   ctrl
);

	step_t  upc_q;
	uword_t uw;
	logic   cond;
	logic   act_en;
	logic   stall;

	cre_urom u_urom (
		.upc (upc_q),
		.uw  (uw)
	);

	always_comb begin
		case (uw.cond)
			COND_ALWAYS: cond = 1'b1;
			COND_ACCEPT: cond = status.accept;
			COND_DASH:   cond = status.dash_held;
			COND_SAME:   cond = status.same_class;
			COND_DONE:   cond = status.range_done;
			COND_HOLD:   cond = status.hold_dash;
			COND_LAST:   cond = status.last;
			default:     cond = 1'b0;
		endcase
	end

	always_comb begin
		case (uw.act)
			ACT_ALWAYS:   act_en = 1'b1;
			ACT_ON_TRUE:  act_en = cond;
			ACT_ON_FALSE: act_en = !cond;
			default:      act_en = 1'b0;
		endcase
		// A step that emits waits while the output register is full and not being taken.
		stall     = act_en && (uw.emit != EMIT_NONE) && status.out_blocked;
		ctrl.uw   = uw;
		ctrl.fire = act_en && !stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= STEP_WAIT;
		end else if (!stall) begin
			upc_q <= cond ? uw.jt : uw.jf;
		end
	end

	assign upc = upc_q;

endmodule

>>> rtl/cre_datapath.sv
// ---------------------------------------------------------------------------
// Range expander datapath
// Input latch, string state, range counter and output register.
// ---------------------------------------------------------------------------
module cre_datapath import cre_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_ctrl_t   ctrl,
	input  logic       req_valid,
	input  in_item_t   req,
	output logic       req_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output out_item_t  rsp,
	output dp_status_t status
);

	in_item_t  in_q;
	logic [7:0] prev_q;
	logic [7:0] cnt_q;
	logic       dash_q;
	logic       seen_q;
	out_item_t  out_q;
	logic       out_valid_q;
	out_item_t  emit_item;
	logic       emit_fire;

	assign req_ready = ctrl.uw.in_ready;

	always_comb begin
		status.accept      = req_valid && ctrl.uw.in_ready;
		status.dash_held   = dash_q;
		status.same_class  = (is_digit(prev_q) && is_digit(in_q.in_byte)) ||
			(is_alpha(prev_q) && is_alpha(in_q.in_byte));
		status.range_done  = cnt_q > in_q.in_byte;
		status.hold_dash   = (in_q.in_byte == DASH_BYTE) && seen_q &&
			(is_digit(prev_q) || is_alpha(prev_q));
		status.last        = in_q.in_last;
		status.out_blocked = out_valid_q && !rsp_ready;
	end

	always_comb begin
		case (ctrl.uw.emit)
			EMIT_CNT:  emit_item = '{out_byte: cnt_q,        out_end: 1'b0};
			EMIT_DASH: emit_item = '{out_byte: DASH_BYTE,    out_end: 1'b0};
			EMIT_BYTE: emit_item = '{out_byte: in_q.in_byte, out_end: 1'b0};
			EMIT_TERM: emit_item = '{out_byte: TERM_BYTE,    out_end: 1'b1};
			default:   emit_item = '{out_byte: TERM_BYTE,    out_end: 1'b0};
		endcase
		emit_fire = ctrl.fire && (ctrl.uw.emit != EMIT_NONE);
	end

	always_ff @(posedge clk) begin
		if (status.accept) begin
			in_q <= req;
		end
		if (ctrl.fire) begin
			case (ctrl.uw.cnt_op)
				CNT_LOAD: cnt_q <= prev_q + 8'd1;
				CNT_INC:  cnt_q <= cnt_q + 8'd1;
				default:  cnt_q <= cnt_q;
			endcase
		end
		if (emit_fire) begin
			out_q <= emit_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q      <= 8'd0;
			dash_q      <= 1'b0;
			seen_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.fire) begin
				case (ctrl.uw.prev_op)
					PREV_BYTE: prev_q <= in_q.in_byte;
					PREV_DASH: prev_q <= DASH_BYTE;
					PREV_ZERO: prev_q <= 8'd0;
					default:   prev_q <= prev_q;
				endcase
				case (ctrl.uw.dash_op)
					FLAG_SET: dash_q <= 1'b1;
					FLAG_CLR: dash_q <= 1'b0;
					default:  dash_q <= dash_q;
				endcase
				case (ctrl.uw.seen_op)
					FLAG_SET: seen_q <= 1'b1;
					FLAG_CLR: seen_q <= 1'b0;
					default:  seen_q <= seen_q;
				endcase
			end
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

>>> rtl/char_range_expander_core.sv
// ---------------------------------------------------------------------------
// Character range expander
// Expands shorthand ranges such as a-z and 0-9 in a byte stream.
// ---------------------------------------------------------------------------
// The block takes a string one byte per item on the req channel, with
// in_last set on the final byte, and returns the expanded string on the rsp
// channel, ended by a terminator item (out_byte 0, out_end 1).
// Both channels use valid/ready; an item moves when both are high.
// Control is a ten-step microprogram held in a ROM. The block takes one
// input item at a time: req_ready is high only in the program's wait step.
// A plain byte passes through the dispatch, body, pass and seen steps
// before the next accept, and its result enters the output register in
// the pass step. The end byte of a range such as a-z goes through the
// class step into the range step, which emits from the counter once per
// cycle while the output register is not stalled, then finds that the
// counter has passed the end byte and moves to the seen step.
// The last byte of a string adds the optional dash flush and the terminator.
// The output register lets the block finish a result while the previous
// one is still waiting; a step that must emit while that register is full
// and not being taken stalls the whole program in place.
// Reset clears the string state and the output valid, and the program
// starts in its wait step, ready for the first byte.
// ---------------------------------------------------------------------------
`include "char_range_expander_core_macros.svh"

module char_range_expander_core import cre_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  in_item_t  req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp
);

	dp_status_t status;
	dp_ctrl_t   ctrl;
	step_t      upc;

	// Step counter and microcode ROM.
	cre_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.upc    (upc),
		.ctrl   (ctrl)
	);

	// Input latch, string state, range counter and the output register.
	cre_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.status    (status)
	);

	// Only the wait step may take a new item.
	`CRE_ASSERT_IMPL(a_ready_in_wait, req_ready, upc == STEP_WAIT, "ready outside wait step")
	// A terminator item always carries a zero byte.
	`CRE_ASSERT_IMPL(a_term_zero, rsp_valid && rsp.out_end,
		rsp.out_byte == TERM_BYTE, "terminator byte not zero")
	// Once the terminator goes out, the program returns to the wait step.
	`CRE_ASSERT_NEXT(a_term_to_wait, (upc == STEP_TERM) && ctrl.fire,
		upc == STEP_WAIT, "no return to wait after terminator")
	// A range step never emits past the range end byte.
	`CRE_ASSERT_IMPL(a_range_bound, (upc == STEP_RANGE) && ctrl.fire,
		!status.range_done, "range step past end byte")

endmodule
